[sv/sce_pkg.sv]
`default_nettype none
package sce_pkg;

  localparam int ID_W = 64;

  // command codes
  localparam logic [2:0] CMD_QUERY   = 3'd0;
  localparam logic [2:0] CMD_INSERT  = 3'd1;
  localparam logic [2:0] CMD_CLEAR   = 3'd2;
  localparam logic [2:0] CMD_MOVE    = 3'd3;
  localparam logic [2:0] CMD_ADVANCE = 3'd4;
  localparam logic [2:0] CMD_SIZE    = 3'd5;

  localparam logic [6:0] COUNT_MAX = 7'd127;

  typedef struct packed {
    logic       hit;
    logic       conflict;
    logic [6:0] stage_count;
    logic [3:0] stage_after;
    logic       dropped;
  } result_t;

endpackage
`default_nettype wire

[sv/staged_entity_conflict_set.sv]
`default_nettype none
// staged entity conflict set: a table of entity ids, each with a mask of the
// pipeline stages that hold it, kept in one synchronous memory
// command channel: a transaction is taken on a rising edge with start high
// and busy low; cmd selects query, insert, clear, move, advance or size
// result channel: every command gives one result, shown for exactly one
// cycle with done high; the receiver cannot stall it, so no result waits
// query, insert, clear, move and advance walk the whole table, one entry per
// cycle through the single read port, then make the final update in a
// finishing state that shows the result; busy stays high until then,
// and the next command may be taken in the cycle the result is shown
// size, an unused command code, and insert, clear, move or advance with an
// invalid stage (or a move with an invalid target) answer without a walk
// reset: rst is synchronous; after it a clearing pass writes every entry free,
// with busy high until it ends
// stage counts live in registers and are updated incrementally
module staged_entity_conflict_set #(
  parameter int STAGES  = 4,
  parameter int ENTRIES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  cmd,
  input  wire logic [3:0]  stage,
  input  wire logic [3:0]  target_stage,
  input  wire logic [63:0] entity_id,
  input  wire logic        last,
  output logic             done,
  output logic             hit,
  output logic             conflict,
  output logic [6:0]       stage_count,
  output logic [3:0]       stage_after,
  output logic             dropped
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(ENTRIES + 1);
  // one word per entry: id above, stage mask below
  localparam int WIDTH = sce_pkg::ID_W + STAGES;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [WIDTH-1:0] mem_wdata;
  logic             mem_re;
  logic [AW-1:0]    mem_raddr;
  logic [WIDTH-1:0] mem_rdata;
  sce_pkg::result_t res;

  sce_table #(
    .WIDTH (WIDTH),
    .DEPTH (ENTRIES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sce_seq #(
    .STAGES  (STAGES),
    .ENTRIES (ENTRIES),
    .AW      (AW),
    .CW      (CW),
    .WIDTH   (WIDTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .stage        (stage),
    .target_stage (target_stage),
    .entity_id    (entity_id),
    .last         (last),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_re       (mem_re),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .res          (res),
    .done         (done)
  );

  // result fields straight from the registered result
  assign hit         = res.hit;
  assign conflict    = res.conflict;
  assign stage_count = res.stage_count;
  assign stage_after = res.stage_after;
  assign dropped     = res.dropped;

endmodule
`default_nettype wire

[sv/sce_table.sv]
`default_nettype none
module sce_table #(
  parameter int WIDTH = 68,
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[sv/sce_seq.sv]
`default_nettype none
module sce_seq #(
  parameter int STAGES  = 4,
  parameter int ENTRIES = 64,
  parameter int AW      = 6,
  parameter int CW      = 7,
  parameter int WIDTH   = 68
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       cmd,
  input  wire logic [3:0]       stage,
  input  wire logic [3:0]       target_stage,
  input  wire logic [63:0]      entity_id,
  input  wire logic             last,
  output logic                  mem_we,
  output logic      [AW-1:0]    mem_waddr,
  output logic      [WIDTH-1:0] mem_wdata,
  output logic                  mem_re,
  output logic      [AW-1:0]    mem_raddr,
  input  wire logic [WIDTH-1:0] mem_rdata,
  output sce_pkg::result_t      res,
  output logic                  done
);

  localparam logic [1:0] ST_CLR   = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam int XW = (CW > 7) ? CW : 7;

  logic [1:0]        state;
  logic [CW-1:0]     cnt;
  logic              rvalid;
  logic [AW-1:0]     pa;
  logic              acc;
  logic [CW-1:0]     counts [STAGES];

  // latched command
  logic [2:0]        cmd_q;
  logic [STAGES-1:0] sb_q;
  logic [STAGES-1:0] tb_q;
  logic              same_q;
  logic [63:0]       id_q;
  logic              last_q;
  logic [3:0]        nxt_q;

  // search results
  logic              found;
  logic [AW-1:0]     fidx;
  logic [STAGES-1:0] fmask;
  logic              free_found;
  logic [AW-1:0]     free_idx;
  logic [CW-1:0]     inc;

  // decode of the incoming command
  logic              sv_in;
  logic              tv_in;
  logic [STAGES-1:0] sb_in;
  logic [STAGES-1:0] tb_in;
  logic [3:0]        nxt_in;
  logic [CW-1:0]     sel_cnt;
  logic [XW-1:0]     sel_cnt_x;
  sce_pkg::result_t  imm_res;

  // sweep data path
  logic [STAGES-1:0] m_r;
  logic [63:0]       id_r;
  logic              is_move;
  logic              mv_hit;
  logic [STAGES-1:0] newm;
  logic              tgt_new;
  logic              ins_write;

  assign busy = (state != ST_IDLE);

  always_comb begin
    sv_in  = stage < 4'(STAGES);
    tv_in  = target_stage < 4'(STAGES);
    sb_in  = STAGES'(1) << stage;
    nxt_in = (stage == 4'(STAGES - 1)) ? 4'd0 : stage + 4'd1;
    tb_in  = (cmd == sce_pkg::CMD_ADVANCE) ? (STAGES'(1) << nxt_in)
                                           : (STAGES'(1) << target_stage);
    sel_cnt = '0;
    for (int s = 0; s < STAGES; s++) begin
      if (stage == 4'(s)) begin
        sel_cnt = counts[s];
      end
    end
    sel_cnt_x = XW'(sel_cnt);
    // answer for commands that finish without a sweep
    imm_res = '0;
    if (cmd == sce_pkg::CMD_SIZE && sv_in) begin
      imm_res.stage_count = (sel_cnt_x > XW'(sce_pkg::COUNT_MAX)) ?
                            sce_pkg::COUNT_MAX : sel_cnt_x[6:0];
    end
    if (cmd == sce_pkg::CMD_ADVANCE && !sv_in) begin
      imm_res.stage_after = stage;
    end
  end

  always_comb begin
    m_r     = mem_rdata[STAGES-1:0];
    id_r    = mem_rdata[WIDTH-1:STAGES];
    is_move = (cmd_q == sce_pkg::CMD_CLEAR) || (cmd_q == sce_pkg::CMD_MOVE) ||
              (cmd_q == sce_pkg::CMD_ADVANCE);
    mv_hit  = |(m_r & sb_q);
    newm    = (m_r & ~sb_q) | (same_q ? '0 : tb_q);
    tgt_new = !same_q && !(|(m_r & tb_q));
    ins_write = (cmd_q == sce_pkg::CMD_INSERT) &&
                (found ? !(|(fmask & sb_q)) : free_found);
  end

  // memory port control; sweep writes hit the entry read in the cycle before,
  // never the one being read, and the insert write comes after the sweep
  always_comb begin
    mem_re    = (state == ST_SWEEP) && (cnt < CW'(ENTRIES));
    mem_raddr = cnt[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = pa;
    mem_wdata = {id_r, newm};
    case (state)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = '0;
      end
      ST_SWEEP: begin
        mem_we = rvalid && is_move && mv_hit;
      end
      ST_FIN: begin
        mem_we    = ins_write;
        mem_waddr = found ? fidx : free_idx;
        mem_wdata = found ? {id_q, fmask | sb_q} : {id_q, sb_q};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_CLR;
      cnt    <= '0;
      rvalid <= 1'b0;
      done   <= 1'b0;
      acc    <= 1'b0;
      for (int s = 0; s < STAGES; s++) begin
        counts[s] <= '0;
      end
    end else begin
      done   <= 1'b0;
      rvalid <= 1'b0;
      case (state)
        ST_CLR: begin
          cnt <= cnt + CW'(1);
          if (cnt == CW'(ENTRIES - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q      <= cmd;
            sb_q       <= sb_in;
            tb_q       <= (cmd == sce_pkg::CMD_CLEAR) ? '0 : tb_in;
            same_q     <= (cmd == sce_pkg::CMD_CLEAR) || (sb_in == tb_in);
            id_q       <= entity_id;
            last_q     <= last;
            nxt_q      <= nxt_in;
            cnt        <= '0;
            found      <= 1'b0;
            free_found <= 1'b0;
            inc        <= '0;
            if ((cmd == sce_pkg::CMD_QUERY) ||
                (sv_in && ((cmd == sce_pkg::CMD_INSERT) ||
                           (cmd == sce_pkg::CMD_CLEAR) ||
                           (cmd == sce_pkg::CMD_ADVANCE) ||
                           (cmd == sce_pkg::CMD_MOVE && tv_in)))) begin
              state <= ST_SWEEP;
              res   <= '0;
            end else begin
              done <= 1'b1;
              res  <= imm_res;
            end
          end
        end
        ST_SWEEP: begin
          if (cnt < CW'(ENTRIES)) begin
            cnt    <= cnt + CW'(1);
            rvalid <= 1'b1;
            pa     <= cnt[AW-1:0];
          end
          if (rvalid) begin
            if ((|m_r) && (id_r == id_q)) begin
              found <= 1'b1;
              fidx  <= pa;
              fmask <= m_r;
            end
            if (!(|m_r) && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= pa;
            end
            if (is_move && mv_hit && tgt_new) begin
              inc <= inc + CW'(1);
            end
            if (pa == AW'(ENTRIES - 1)) begin
              state <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          state <= ST_IDLE;
          done  <= 1'b1;
          case (cmd_q)
            sce_pkg::CMD_QUERY: begin
              res.hit      <= found;
              res.conflict <= acc | found;
              acc          <= last_q ? 1'b0 : (acc | found);
            end
            sce_pkg::CMD_INSERT: begin
              res.dropped <= !found && !free_found;
              for (int s = 0; s < STAGES; s++) begin
                if (sb_q[s] && ins_write) begin
                  counts[s] <= counts[s] + CW'(1);
                end
              end
            end
            default: begin
              if (cmd_q == sce_pkg::CMD_ADVANCE) begin
                res.stage_after <= nxt_q;
              end
              for (int s = 0; s < STAGES; s++) begin
                if (sb_q[s]) begin
                  counts[s] <= '0;
                end else if (tb_q[s]) begin
                  counts[s] <= counts[s] + inc;
                end
              end
            end
          endcase
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
